[src/tfc_pkg.sv]
`timescale 1ns / 1ps

package tfc_pkg;

   // Ethernet / IPv4 framing, fixed 20-byte IP header
   localparam int ETH_HDR_LEN = 14;
   localparam int IP_HDR_LEN  = 20;
   localparam int L4_HDR_LEN  = 20;

   // byte offsets of captured fields, counted from the destination MAC
   localparam logic [5:0] POS_ETYPE    = 6'd12;
   localparam logic [5:0] POS_PROTOCOL = 6'(ETH_HDR_LEN + 9);
   localparam logic [5:0] POS_SRC_ADDR = 6'(ETH_HDR_LEN + 12);
   localparam logic [5:0] POS_DST_ADDR = 6'(ETH_HDR_LEN + 16);
   localparam logic [5:0] POS_SRC_PORT = 6'(ETH_HDR_LEN + IP_HDR_LEN);
   localparam logic [5:0] POS_DST_PORT = 6'(ETH_HDR_LEN + IP_HDR_LEN + 2);
   localparam logic [5:0] POS_MAX      = 6'd63;

   // position of the final byte of the shortest frame that is counted
   localparam logic [5:0] MIN_LAST_POS = 6'(ETH_HDR_LEN + IP_HDR_LEN + L4_HDR_LEN - 1);

   localparam logic [15:0] IP_ETHER_TYPE = 16'h0800;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;

   localparam int KEY_W   = 104;
   localparam int COUNT_W = 32;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // captured header of the frame in flight
   typedef struct packed {
      logic [5:0]  pos;
      logic [15:0] ether_type;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } header_type;

   typedef enum logic [2:0] {
      ST_CAPTURE,
      ST_DECIDE,
      ST_SCAN,
      ST_WRITE,
      ST_EMIT
   } state_type;

endpackage

[src/five_tuple_flow_counter_unit.sv]
`timescale 1ns / 1ps
// Frame bytes are taken one per cycle; req_tready drops after the final byte until its result
// is loaded. Passed frame: the decide state goes on to the emit state. Counted frame: the
// flow table scan reads one entry per cycle until a hit or the fill count, then a hit or new
// flow writes its entry back before emit; with the table full, the scan goes on to emit.
// Synchronous active-high reset clears the header capture, the fill count and the output;
// table contents are not cleared, entries at or above the fill count are never read as flows.

module five_tuple_flow_counter_unit import tfc_pkg::*; #(
   parameter int FLOW_ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] flow_count
   output logic [1:0]  rsp_tuser    // [0] verdict, [1] table_full
);

   localparam int IDX_W  = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int FILL_W = $clog2(FLOW_ENTRIES + 1);
   localparam int WORD_W = KEY_W + COUNT_W;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FLOW_ENTRIES);

   state_type state_ff, state_in;
   header_type hdr;
   logic byte_accept, frame_clear, mem_we, load_rsp;

   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]   target_ff, target_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic               res_verdict_ff, res_verdict_in;
   logic               res_full_ff, res_full_in;
   logic [WORD_W-1:0]  rd_word_ff;

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]        rsp_tdata_ff;
   logic [1:0]         rsp_tuser_ff;

   logic [KEY_W-1:0]   flow_key;
   logic [KEY_W-1:0]   rd_key;
   logic [COUNT_W-1:0] rd_count;
   logic               eligible, hit, scan_done, out_free;

   // flow table: key in the upper bits, packet count in the lower
   logic [WORD_W-1:0] flow_mem [FLOW_ENTRIES];

   tfc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_tdata),
      .last_byte   (req_tlast),
      .frame_clear (frame_clear),
      .hdr         (hdr)
   );

   assign byte_accept = req_tvalid && req_tready;

   // classification of the captured header
   assign flow_key = {hdr.src_addr, hdr.dst_addr, hdr.src_port, hdr.dst_port, hdr.protocol};
   assign eligible = (hdr.pos >= MIN_LAST_POS) && (hdr.ether_type == IP_ETHER_TYPE) &&
                     ((hdr.protocol == PROTO_TCP) || (hdr.protocol == PROTO_UDP));

   assign rd_key    = rd_word_ff[WORD_W-1:COUNT_W];
   assign rd_count  = rd_word_ff[COUNT_W-1:0];
   assign hit       = pend_ff && (rd_key == flow_key);
   assign scan_done = (issue_ff == fill_ff);
   assign out_free  = !rsp_tvalid_ff || rsp_tready;

   // next state and control
   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      frame_clear    = 1'b0;
      mem_we         = 1'b0;
      load_rsp       = 1'b0;
      fill_in        = fill_ff;
      issue_in       = issue_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      target_in      = target_ff;
      res_count_in   = res_count_ff;
      res_verdict_in = res_verdict_ff;
      res_full_in    = res_full_ff;
      case (state_ff)
         ST_CAPTURE: begin
            req_tready = 1'b1;
            if (req_tvalid && req_tlast) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_count_in   = '0;
            res_verdict_in = 1'b0;
            res_full_in    = 1'b0;
            issue_in       = '0;
            state_in       = eligible ? ST_SCAN : ST_EMIT;
         end
         ST_SCAN: begin
            if (hit) begin
               // known flow, count saturates at the top
               res_verdict_in = 1'b1;
               res_count_in   = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1);
               target_in      = pend_idx_ff;
               state_in       = ST_WRITE;
            end else if (scan_done) begin
               res_verdict_in = 1'b1;
               if (fill_ff != FILL_MAX) begin
                  // new flow takes the next free slot
                  res_count_in = COUNT_W'(1);
                  target_in    = fill_ff[IDX_W-1:0];
                  fill_in      = fill_ff + FILL_W'(1);
                  state_in     = ST_WRITE;
               end else begin
                  res_full_in = 1'b1;
                  state_in    = ST_EMIT;
               end
            end else begin
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + FILL_W'(1);
            end
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               frame_clear = 1'b1;
               state_in    = ST_CAPTURE;
            end
         end
         default: begin
            state_in = ST_CAPTURE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CAPTURE;
         fill_ff  <= '0;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
      end
   end

   // scan and result payload
   always_ff @(posedge clock) begin
      pend_idx_ff    <= pend_idx_in;
      target_ff      <= target_in;
      res_count_ff   <= res_count_in;
      res_verdict_ff <= res_verdict_in;
      res_full_ff    <= res_full_in;
   end

   // flow table port: read every cycle at the scan pointer, write back one entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         flow_mem[target_ff] <= {flow_key, res_count_ff};
      end
      rd_word_ff <= flow_mem[issue_ff[IDX_W-1:0]];
   end

   // output register, holds a result until its transfer
   assign rsp_tvalid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_tdata_ff <= res_count_ff;
         rsp_tuser_ff <= {res_full_ff, res_verdict_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

[src/tfc_parser.sv]
`timescale 1ns / 1ps

module tfc_parser import tfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_accept,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  logic       frame_clear,
   output header_type hdr
);

   header_type hdr_ff, hdr_in;

   // shift header bytes in, big-endian, by position in the frame
   always_comb begin
      hdr_in = hdr_ff;
      if (frame_clear) begin
         hdr_in = '0;
      end else if (byte_accept) begin
         case (hdr_ff.pos) inside
            POS_ETYPE, POS_ETYPE + 6'd1: begin
               hdr_in.ether_type = {hdr_ff.ether_type[7:0], data_byte};
            end
            POS_PROTOCOL: begin
               hdr_in.protocol = data_byte;
            end
            [POS_SRC_ADDR : POS_SRC_ADDR + 6'd3]: begin
               hdr_in.src_addr = {hdr_ff.src_addr[23:0], data_byte};
            end
            [POS_DST_ADDR : POS_DST_ADDR + 6'd3]: begin
               hdr_in.dst_addr = {hdr_ff.dst_addr[23:0], data_byte};
            end
            POS_SRC_PORT, POS_SRC_PORT + 6'd1: begin
               hdr_in.src_port = {hdr_ff.src_port[7:0], data_byte};
            end
            POS_DST_PORT, POS_DST_PORT + 6'd1: begin
               hdr_in.dst_port = {hdr_ff.dst_port[7:0], data_byte};
            end
            default: begin
            end
         endcase
         // position holds on the final byte so it can be checked afterwards
         if (!last_byte && hdr_ff.pos != POS_MAX) begin
            hdr_in.pos = hdr_ff.pos + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= '0;
      end else begin
         hdr_ff <= hdr_in;
      end
   end

   assign hdr = hdr_ff;

endmodule

[src/tfc_checker.sv]
`timescale 1ns / 1ps

module tfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a passed frame carries no count and no full flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 32'd0 && !rsp_tuser[1])
      else $error("passed frame with count or full flag");

   // full table: frame dropped, count zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && rsp_tdata == 32'd0)
      else $error("table full result malformed");

   // a counted flow always has a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && !rsp_tuser[1] |-> rsp_tdata != 32'd0)
      else $error("counted flow with zero count");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind five_tuple_flow_counter_unit tfc_checker u_tfc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[verif/tb_five_tuple_flow_counter_unit.sv]
`timescale 1ns / 1ps

module tb_five_tuple_flow_counter_unit;
   import tfc_pkg::*;

   localparam int FLOW_SLOTS    = 32;
   localparam int POOL_SIZE     = 20;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = FLOW_SLOTS + 8;
   localparam int MIN_FRAME_LEN = 54;

   // byte offsets from the destination MAC, fixed 20-byte IP header
   localparam int AT_ETHER_TYPE = 12;
   localparam int AT_PROTOCOL   = 23;
   localparam int AT_SRC_ADDR   = 26;
   localparam int AT_DST_ADDR   = 30;
   localparam int AT_SRC_PORT   = 34;
   localparam int AT_DST_PORT   = 36;
   localparam int LAST_POS_MIN  = MIN_FRAME_LEN - 1;
   localparam logic [5:0] POS_TOP = 6'd63;

   typedef struct packed {
      logic [15:0] ether_type;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } frame_header_type;

   typedef struct packed {
      logic        verdict;
      logic [31:0] flow_count;
      logic        table_full;
   } flow_verdict_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] flow_count
   logic [1:0]  rsp_tuser;            // [0] verdict, [1] table_full

   // header capture of the frame in flight
   logic [5:0]  cap_pos        = '0;
   logic [15:0] cap_ether_type = '0;
   logic [7:0]  cap_protocol   = '0;
   logic [31:0] cap_src_addr   = '0;
   logic [31:0] cap_dst_addr   = '0;
   logic [15:0] cap_src_port   = '0;
   logic [15:0] cap_dst_port   = '0;

   // flow table copy
   logic [63:0] slot_addr_key [FLOW_SLOTS];
   logic [39:0] slot_port_key [FLOW_SLOTS];
   bit          slot_used     [FLOW_SLOTS];
   logic [31:0] slot_count    [FLOW_SLOTS];

   flow_verdict_type pending_verdicts[$];
   frame_header_type flow_pool[POOL_SIZE];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;
   int error_count   = 0;
   int quiet_cycles  = 0;
   int items_sent    = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   five_tuple_flow_counter_unit #(
      .FLOW_ENTRIES(FLOW_SLOTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // Capture one byte; on the final byte look up the flow and return the verdict
   function automatic bit predict_flow_update(input logic [7:0] b, input logic last,
                                              output flow_verdict_type v);
      int          p;
      logic [63:0] addr_key;
      logic [39:0] port_key;
      int          hit;
      int          free_slot;
      p = int'(cap_pos);
      v = '0;
      if (p == AT_ETHER_TYPE || p == AT_ETHER_TYPE + 1)
         cap_ether_type = {cap_ether_type[7:0], b};
      else if (p == AT_PROTOCOL)
         cap_protocol = b;
      else if (p >= AT_SRC_ADDR && p < AT_SRC_ADDR + 4)
         cap_src_addr = {cap_src_addr[23:0], b};
      else if (p >= AT_DST_ADDR && p < AT_DST_ADDR + 4)
         cap_dst_addr = {cap_dst_addr[23:0], b};
      else if (p == AT_SRC_PORT || p == AT_SRC_PORT + 1)
         cap_src_port = {cap_src_port[7:0], b};
      else if (p == AT_DST_PORT || p == AT_DST_PORT + 1)
         cap_dst_port = {cap_dst_port[7:0], b};

      if (!last) begin
         if (cap_pos != POS_TOP)
            cap_pos = cap_pos + 6'd1;
         return 1'b0;
      end

      if (p >= LAST_POS_MIN && cap_ether_type == IP_ETHER_TYPE &&
          (cap_protocol == PROTO_TCP || cap_protocol == PROTO_UDP)) begin
         addr_key  = {cap_src_addr, cap_dst_addr};
         port_key  = {cap_src_port, cap_dst_port, cap_protocol};
         hit       = -1;
         free_slot = -1;
         for (int i = 0; i < FLOW_SLOTS; i++) begin
            if (slot_used[i]) begin
               if (hit < 0 && slot_addr_key[i] == addr_key && slot_port_key[i] == port_key)
                  hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         v.verdict = 1'b1;
         if (hit >= 0) begin
            // saturating packet count
            if (slot_count[hit] != COUNT_MAX)
               slot_count[hit] = slot_count[hit] + 32'd1;
            v.flow_count = slot_count[hit];
         end else if (free_slot >= 0) begin
            slot_used[free_slot]     = 1'b1;
            slot_addr_key[free_slot] = addr_key;
            slot_port_key[free_slot] = port_key;
            slot_count[free_slot]    = 32'd1;
            v.flow_count             = 32'd1;
         end else begin
            v.table_full = 1'b1;
         end
      end

      cap_pos        = '0;
      cap_ether_type = '0;
      cap_protocol   = '0;
      cap_src_addr   = '0;
      cap_dst_addr   = '0;
      cap_src_port   = '0;
      cap_dst_port   = '0;
      return 1'b1;
   endfunction

   // Byte i of a frame carrying header h; everything else is random payload
   function automatic logic [7:0] frame_byte(input frame_header_type h, input int i);
      if (i == AT_ETHER_TYPE)     return h.ether_type[15:8];
      if (i == AT_ETHER_TYPE + 1) return h.ether_type[7:0];
      if (i == AT_PROTOCOL)       return h.protocol;
      if (i >= AT_SRC_ADDR && i < AT_SRC_ADDR + 4)
         return h.src_addr[8 * (AT_SRC_ADDR + 3 - i) +: 8];
      if (i >= AT_DST_ADDR && i < AT_DST_ADDR + 4)
         return h.dst_addr[8 * (AT_DST_ADDR + 3 - i) +: 8];
      if (i == AT_SRC_PORT)       return h.src_port[15:8];
      if (i == AT_SRC_PORT + 1)   return h.src_port[7:0];
      if (i == AT_DST_PORT)       return h.dst_port[15:8];
      if (i == AT_DST_PORT + 1)   return h.dst_port[7:0];
      return 8'($urandom);
   endfunction

   function automatic frame_header_type fresh_flow();
      frame_header_type h;
      h.ether_type = IP_ETHER_TYPE;
      h.protocol   = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
      h.src_addr   = $urandom;
      h.dst_addr   = $urandom;
      h.src_port   = 16'($urandom);
      h.dst_port   = 16'($urandom);
      return h;
   endfunction

   // One byte transfer; entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic last);
      flow_verdict_type v;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
      if (predict_flow_update(b, last, v))
         pending_verdicts.push_back(v);
      @(negedge clock);
   endtask

   task automatic send_frame(input frame_header_type h, input int len);
      for (int i = 0; i < len; i++)
         send_byte(frame_byte(h, i), i == len - 1);
   endtask

   // Stop offering bytes until every verdict has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_verdicts.size() != 0)
         @(negedge clock);
   endtask

   // Frames that must pass: too short, not IPv4, not TCP/UDP
   task automatic test_pass_conditions();
      logic [15:0]      odd_types[4]  = '{16'h0801, 16'h8100, 16'h0000, 16'hFFFF};
      logic [7:0]       odd_protos[7] = '{8'd0, 8'd1, 8'd5, 8'd7, 8'd16, 8'd18, 8'd255};
      frame_header_type h;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      for (int i = 0; i < 60; i++)
         send_byte(8'hFF, i == 59);
      for (int i = 0; i < 60; i++)
         send_byte(8'h00, i == 59);
      send_frame(flow_pool[2], MIN_FRAME_LEN - 1);
      foreach (odd_types[i]) begin
         h = flow_pool[3];
         h.ether_type = odd_types[i];
         send_frame(h, MIN_FRAME_LEN);
      end
      foreach (odd_protos[i]) begin
         h = flow_pool[4];
         h.protocol = odd_protos[i];
         send_frame(h, MIN_FRAME_LEN + 2);
      end
      wait_results_drained();
   endtask

   // New flows, repeat hits, keys differing only in protocol, long frames
   task automatic test_flow_counting();
      frame_header_type lo;
      frame_header_type hi;
      lo            = '0;
      lo.ether_type = IP_ETHER_TYPE;
      lo.protocol   = PROTO_TCP;
      hi            = '1;
      hi.ether_type = IP_ETHER_TYPE;
      hi.protocol   = PROTO_UDP;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_frame(lo, MIN_FRAME_LEN);
      send_frame(lo, MIN_FRAME_LEN);
      send_frame(hi, 64);
      hi.protocol = PROTO_TCP;
      send_frame(hi, 64);
      send_frame(lo, 63);
      send_frame(lo, 64);
      send_frame(lo, 100);
      wait_results_drained();
   endtask

   // Receiver holds off long enough for the input side to stall
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 400;
      repeat (4) send_frame(flow_pool[$urandom_range(POOL_SIZE - 1)], $urandom_range(1, 8));
      send_frame(flow_pool[1], MIN_FRAME_LEN);
      wait_results_drained();
   endtask

   // Fill every slot with new flows, then overflow and hit a stored flow
   task automatic test_table_full();
      int used;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      forever begin
         used = 0;
         foreach (slot_used[i])
            used += slot_used[i];
         if (used == FLOW_SLOTS)
            break;
         send_frame(fresh_flow(), MIN_FRAME_LEN);
      end
      repeat (3) send_frame(fresh_flow(), MIN_FRAME_LEN);
      send_frame(flow_pool[0], MIN_FRAME_LEN + 6);
      wait_results_drained();
   endtask

   // Mostly well-formed flows from the pool, plus new flows, runts and junk
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int min_items, input int min_frames);
      int               first_item;
      int               frames;
      int               kind;
      int               len;
      frame_header_type h;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first_item    = items_sent;
      frames        = 0;
      while (items_sent - first_item < min_items || frames < min_frames) begin
         kind = $urandom_range(99);
         len  = ($urandom_range(9) == 0) ? $urandom_range(MIN_FRAME_LEN, 100)
                                         : $urandom_range(MIN_FRAME_LEN, MIN_FRAME_LEN + 4);
         h    = flow_pool[$urandom_range(POOL_SIZE - 1)];
         if (kind < 55) begin
            send_frame(h, len);
         end else if (kind < 70) begin
            send_frame(fresh_flow(), len);
         end else if (kind < 80) begin
            send_frame(h, $urandom_range(1, MIN_FRAME_LEN - 1));
         end else if (kind < 90) begin
            if ($urandom_range(1))
               h.ether_type = 16'($urandom);
            else
               h.protocol = 8'($urandom);
            send_frame(h, len);
         end else begin
            h            = fresh_flow();
            h.ether_type = $urandom_range(1) ? IP_ETHER_TYPE : 16'($urandom);
            h.protocol   = 8'($urandom);
            send_frame(h, $urandom_range(1, 80));
         end
         frames++;
      end
   endtask

   // Receiver: long hold-off when requested, else random stalls
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Compare each result transfer with the oldest predicted verdict
   always @(posedge clock) begin
      flow_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $error("result transfer with no verdict pending: count %0d, user %b",
                   rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tuser[0] !== want.verdict) begin
               $error("verdict: expected %0d, actual %0d", want.verdict, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tdata !== want.flow_count) begin
               $error("flow_count: expected %0d, actual %0d", want.flow_count, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[1] !== want.table_full) begin
               $error("table_full: expected %0d, actual %0d", want.table_full, rsp_tuser[1]);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // flow pool: odd entries differ from their neighbor in one key field
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i % 2 == 0) begin
            flow_pool[i] = fresh_flow();
         end else begin
            flow_pool[i] = flow_pool[i - 1];
            case ($urandom_range(4))
               0: flow_pool[i].src_addr ^= 32'd1 << $urandom_range(31);
               1: flow_pool[i].dst_addr ^= 32'd1 << $urandom_range(31);
               2: flow_pool[i].src_port ^= 16'd1 << $urandom_range(15);
               3: flow_pool[i].dst_port ^= 16'd1 << $urandom_range(15);
               default: flow_pool[i].protocol = (flow_pool[i].protocol == PROTO_TCP) ?
                                                PROTO_UDP : PROTO_TCP;
            endcase
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_pass_conditions();
      test_flow_counting();
      test_output_hold_off();
      test_random_traffic(0, 0, 120, 2);
      test_random_traffic(63, 0, 120, 2);
      test_random_traffic(0, 63, 120, 2);
      test_random_traffic(34, 34, 120, 2);
      test_table_full();
      test_random_traffic(34, 34, 120, 2);
      wait_results_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[sim.f]
src/tfc_pkg.sv
src/tfc_parser.sv
src/five_tuple_flow_counter_unit.sv
src/tfc_checker.sv
verif/tb_five_tuple_flow_counter_unit.sv
